// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is checked during reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bdot_pkg.sv =====
package bdot_pkg;

    // Sequencer states of the command block
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAX,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_DONE
    } state_t;

    // Status of the shared serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Configuration register indexes
    localparam logic REG_POLARITY = 1'b0;
    localparam logic REG_FILTER   = 1'b1;

    localparam int PERC_W = 7;
    localparam logic [7:0] PERC_MAX = 8'd127;
    localparam int QUOT_W = 8;
    localparam int NUM_AXES = 3;

endpackage

// ===== design/bdot_magnetorquer_command.sv =====
// Channel   | Dir | Handshake              | Contents
// s_*       | in  | s_tvalid / s_tready    | one B-dot sample: bdot_x, bdot_y, bdot_z
// m_*       | out | m_tvalid / m_tready    | one command: perc/dir for x, y, z
// APB       | in  | psel & penable & pwrite| polarity_invert (0x0), filter_enable (0x4)
//
// After acceptance, ST_MAX finds the largest magnitude; each axis then runs multiply,
// divider start, eight divider steps and pickup, and ST_DONE moves the result out.
// No new sample is taken until that move; the serial divider is shared by all axes.
// An all-zero vector skips the divider and goes from ST_MAX straight to ST_DONE.
// Reset (rst_n, asynchronous) clears the filter state, both registers and all control.
// A stalled result holds at the output; the next item is taken and waits in ST_DONE.
`include "assert_macros.svh"

module bdot_magnetorquer_command #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int OUTPUT_SCALE = 100,
    localparam int IN_BITS = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    // bdot_x, bdot_y, bdot_z (SAMPLE_WIDTH bits each, signed), zero padded
    input  logic [IN_BITS-1:0] s_tdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    // perc_x[6:0], dir_x, perc_y, dir_y, perc_z, dir_z
    output logic [23:0]        m_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int W     = SAMPLE_WIDTH;
    localparam int PROD_W = SAMPLE_WIDTH + bdot_pkg::QUOT_W;
    localparam logic [bdot_pkg::QUOT_W-1:0] SCALE = bdot_pkg::QUOT_W'(OUTPUT_SCALE);

    // Configuration registers
    logic polarity_reg;
    logic filter_en_reg;
    logic cfg_wr;

    // Datapath state
    bdot_pkg::state_t                 state_reg, state_next;
    logic signed [W-1:0]              filt_reg [bdot_pkg::NUM_AXES];
    logic signed [W-1:0]              filt_next[bdot_pkg::NUM_AXES];
    logic signed [W-1:0]              b_reg    [bdot_pkg::NUM_AXES];
    logic signed [W-1:0]              b_next   [bdot_pkg::NUM_AXES];
    logic [W-1:0]                     m_reg, m_next;
    logic [1:0]                       axis_reg, axis_next;
    logic [PROD_W-1:0]                prod_reg, prod_next;
    logic [bdot_pkg::PERC_W-1:0]      res_perc_reg [bdot_pkg::NUM_AXES];
    logic [bdot_pkg::PERC_W-1:0]      res_perc_next[bdot_pkg::NUM_AXES];
    logic                             res_dir_reg  [bdot_pkg::NUM_AXES];
    logic                             res_dir_next [bdot_pkg::NUM_AXES];
    logic [bdot_pkg::PERC_W-1:0]      out_perc_reg [bdot_pkg::NUM_AXES];
    logic [bdot_pkg::PERC_W-1:0]      out_perc_next[bdot_pkg::NUM_AXES];
    logic                             out_dir_reg  [bdot_pkg::NUM_AXES];
    logic                             out_dir_next [bdot_pkg::NUM_AXES];
    logic                             out_valid_reg, out_valid_next;

    // Combinational helpers
    logic signed [W-1:0]              samp   [bdot_pkg::NUM_AXES];
    logic signed [W-1:0]              avg    [bdot_pkg::NUM_AXES];
    logic [W:0]                       sum    [bdot_pkg::NUM_AXES];
    logic [W-1:0]                     mag_b  [bdot_pkg::NUM_AXES];
    logic [W-1:0]                     max_xy;
    logic [W-1:0]                     max_all;
    logic [W-1:0]                     mag_sel;
    logic [bdot_pkg::QUOT_W-1:0]      q_sat;
    logic                             div_start;
    bdot_pkg::div_stat_t              div_stat;
    logic [bdot_pkg::QUOT_W-1:0]      div_quot;
    logic                             in_acc;

    // ---------------------------------------------------------------
    // APB configuration port: one-wait-free writes, reads of bit 0
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polarity_reg  <= 1'b0;
            filter_en_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                bdot_pkg::REG_POLARITY: polarity_reg  <= pwdata[0];
                bdot_pkg::REG_FILTER:   filter_en_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bdot_pkg::REG_POLARITY: prdata = {31'd0, polarity_reg};
            bdot_pkg::REG_FILTER:   prdata = {31'd0, filter_en_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sample unpack, equal-weight filter and magnitudes
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < bdot_pkg::NUM_AXES; i++)
        begin
            samp[i]  = s_tdata[i*W +: W];
            // floor((old + new) / 2): add one bit wider, drop the lsb
            sum[i]   = {filt_reg[i][W-1], filt_reg[i]} + {samp[i][W-1], samp[i]};
            avg[i]   = sum[i][W:1];
            mag_b[i] = b_reg[i][W-1] ? W'(-b_reg[i]) : W'(b_reg[i]);
        end
        max_xy  = (mag_b[0] > mag_b[1]) ? mag_b[0] : mag_b[1];
        max_all = (max_xy > mag_b[2]) ? max_xy : mag_b[2];
        mag_sel = b_reg[axis_reg][W-1] ? W'(-b_reg[axis_reg]) : W'(b_reg[axis_reg]);
        q_sat   = (div_quot > bdot_pkg::PERC_MAX) ? bdot_pkg::PERC_MAX : div_quot;
    end

    assign s_tready = (state_reg == bdot_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Sequencer: latch, find max (a zero vector skips to done), then multiply/divide each axis
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        filt_next      = filt_reg;
        b_next         = b_reg;
        m_next         = m_reg;
        axis_next      = axis_reg;
        prod_next      = prod_reg;
        res_perc_next  = res_perc_reg;
        res_dir_next   = res_dir_reg;
        out_perc_next  = out_perc_reg;
        out_dir_next   = out_dir_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;

        // drop the result once the sink takes it
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            bdot_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    for (int i = 0; i < bdot_pkg::NUM_AXES; i++)
                    begin
                        if (filter_en_reg)
                        begin
                            b_next[i]    = avg[i];
                            filt_next[i] = avg[i];
                        end
                        else
                            b_next[i] = samp[i];
                    end
                    state_next = bdot_pkg::ST_MAX;
                end
            end
            bdot_pkg::ST_MAX:
            begin
                m_next    = max_all;
                axis_next = 2'd0;
                if (max_all == '0)
                begin
                    // zero vector: every axis reads 0 percent, direction 1
                    for (int i = 0; i < bdot_pkg::NUM_AXES; i++)
                    begin
                        res_perc_next[i] = '0;
                        res_dir_next[i]  = 1'b1;
                    end
                    state_next = bdot_pkg::ST_DONE;
                end
                else
                    state_next = bdot_pkg::ST_MUL;
            end
            bdot_pkg::ST_MUL:
            begin
                prod_next  = PROD_W'(mag_sel) * PROD_W'(SCALE);
                state_next = bdot_pkg::ST_DSTART;
            end
            bdot_pkg::ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = bdot_pkg::ST_DIV;
            end
            bdot_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    res_perc_next[axis_reg] = q_sat[bdot_pkg::PERC_W-1:0];
                    // a command that truncates to zero counts as nonnegative
                    res_dir_next[axis_reg]  = (div_quot == '0) ? 1'b1 :
                                              (b_reg[axis_reg][W-1] ^ polarity_reg);
                    if (axis_reg == 2'd2)
                        state_next = bdot_pkg::ST_DONE;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = bdot_pkg::ST_MUL;
                    end
                end
            end
            bdot_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_perc_next  = res_perc_reg;
                    out_dir_next   = res_dir_reg;
                    out_valid_next = 1'b1;
                    state_next     = bdot_pkg::ST_IDLE;
                end
            end
            default:
                state_next = bdot_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdot_pkg::ST_IDLE;
            axis_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < bdot_pkg::NUM_AXES; i++)
                filt_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            filt_reg      <= filt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg        <= b_next;
        m_reg        <= m_next;
        prod_reg     <= prod_next;
        res_perc_reg <= res_perc_next;
        res_dir_reg  <= res_dir_next;
        out_perc_reg <= out_perc_next;
        out_dir_reg  <= out_dir_next;
    end

    bdot_div #(
        .WIDTH (W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (prod_reg),
        .denom (m_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_dir_reg[2], out_perc_reg[2],
                       out_dir_reg[1], out_perc_reg[1],
                       out_dir_reg[0], out_perc_reg[0]};

    `ASSERT_CLK(a_done_in_div, clk, rst_n,
        div_stat.done |-> (state_reg == bdot_pkg::ST_DIV),
        "divider finished outside divide state")
    `ASSERT_CLK(a_axis_range, clk, rst_n, (axis_reg != 2'd3), "axis index out of range")
    `ASSERT_CLK(a_valid_from_done, clk, rst_n,
        $rose(m_tvalid) |-> ($past(state_reg) == bdot_pkg::ST_DONE),
        "result shown without a finished item")
    `ASSERT_CLK(a_start_nonzero, clk, rst_n, div_start |-> (m_reg != '0),
        "divider started with zero divisor")

endmodule

// ===== design/bdot_div.sv =====
`include "assert_macros.svh"

module bdot_div #(
    parameter int WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [WIDTH+bdot_pkg::QUOT_W-1:0] numer,
    input  logic [WIDTH-1:0]                denom,
    output bdot_pkg::div_stat_t             stat,
    output logic [bdot_pkg::QUOT_W-1:0]     quot
);

    // Quotient is known to fit QUOT_W bits, so the top WIDTH bits of the
    // numerator start as the partial remainder (already below the divisor).
    logic [WIDTH-1:0]                rem_reg, rem_next;
    logic [WIDTH-1:0]                den_reg, den_next;
    logic [bdot_pkg::QUOT_W-1:0]     low_reg, low_next;
    logic [bdot_pkg::QUOT_W-1:0]     q_reg, q_next;
    logic [2:0]                      cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [WIDTH:0]                  trial;
    logic                            ge;

    always_comb
    begin
        trial = {rem_reg, low_reg[bdot_pkg::QUOT_W-1]};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numer[WIDTH+bdot_pkg::QUOT_W-1:bdot_pkg::QUOT_W];
            low_next  = numer[bdot_pkg::QUOT_W-1:0];
            den_next  = denom;
            cnt_next  = 3'd7;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle: shift in, compare, subtract
            rem_next = ge ? WIDTH'(trial - {1'b0, den_reg}) : trial[WIDTH-1:0];
            q_next   = {q_reg[bdot_pkg::QUOT_W-2:0], ge};
            low_next = {low_reg[bdot_pkg::QUOT_W-2:0], 1'b0};
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

    `ASSERT_CLK(a_rem_below_den, clk, rst_n, busy_reg |-> (rem_reg < den_reg), "remainder not below divisor")
    `ASSERT_CLK(a_done_after_busy, clk, rst_n, done_reg |-> $past(busy_reg), "divider done without work")

endmodule

// ===== verif/tb.sv =====
module tb;

    localparam int SAMPLE_BITS    = 16;
    localparam int CMD_SCALE      = 100;
    localparam int PHASE_ITEMS    = 306;
    localparam int WATCHDOG_LIMIT = 5000;
    // Settle time after the final drain gives the tail some margin.
    localparam int SETTLE_CYCLES  = 40;

    // One axis of a torquer command as it sits in m_tdata: perc in [6:0], dir in [7].
    typedef struct packed {
        logic       dir;
        logic [6:0] perc;
    } axis_cmd_t;

    // Index 0 is X in the low byte, Z in the high byte.
    typedef axis_cmd_t [bdot_pkg::NUM_AXES-1:0] command_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    // bdot_x[15:0], bdot_y[31:16], bdot_z[47:32]
    logic [47:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // perc_x[6:0], dir_x[7], perc_y[14:8], dir_y[15], perc_z[22:16], dir_z[23]
    logic [23:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicts torquer commands from accepted B-dot samples and checks the block's output.
    class cmd_scoreboard;
        logic signed [SAMPLE_BITS-1:0] filt_state [bdot_pkg::NUM_AXES];
        logic                          pol_inv;
        logic                          filt_on;
        command_t                      pending_cmds [$];
        int                            mismatches;

        function new();
            for (int a = 0; a < bdot_pkg::NUM_AXES; a++)
                filt_state[a] = '0;
            pol_inv    = 1'b0;
            filt_on    = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, logic bit0);
            if (idx == bdot_pkg::REG_POLARITY)
                pol_inv = bit0;
            else if (idx == bdot_pkg::REG_FILTER)
                filt_on = bit0;
        endfunction

        function int outstanding();
            return pending_cmds.size();
        endfunction

        // Filter (if on), normalize to the largest magnitude, then scale and sign.
        function void take_sample(logic [47:0] d);
            logic signed [SAMPLE_BITS-1:0] raw;
            logic signed [SAMPLE_BITS:0]   total;
            int                            val [bdot_pkg::NUM_AXES];
            int                            mag [bdot_pkg::NUM_AXES];
            int                            peak;
            int                            q;
            logic                          neg;
            command_t                      cmd;
            peak = 0;
            for (int a = 0; a < bdot_pkg::NUM_AXES; a++)
            begin
                raw = d[SAMPLE_BITS*a +: SAMPLE_BITS];
                if (filt_on)
                begin
                    // floor((old + new) / 2) on a 17-bit sum
                    total = {raw[SAMPLE_BITS-1], raw}
                          + {filt_state[a][SAMPLE_BITS-1], filt_state[a]};
                    raw = total[SAMPLE_BITS:1];
                    filt_state[a] = raw;
                end
                val[a] = raw;
                mag[a] = (val[a] < 0) ? -val[a] : val[a];
                if (mag[a] > peak)
                    peak = mag[a];
            end
            for (int a = 0; a < bdot_pkg::NUM_AXES; a++)
            begin
                q = 0;
                cmd[a].dir = 1'b1;
                if (peak != 0)
                begin
                    q = (CMD_SCALE * mag[a]) / peak;
                    // command is -scale*b/m, so a positive b drives negative
                    if (q != 0)
                    begin
                        neg = (val[a] > 0);
                        if (pol_inv)
                            neg = !neg;
                        cmd[a].dir = !neg;
                    end
                end
                if (q > bdot_pkg::PERC_MAX)
                    q = bdot_pkg::PERC_MAX;
                cmd[a].perc = q[6:0];
            end
            pending_cmds.push_back(cmd);
        endfunction

        function void check_command(logic [23:0] d);
            command_t got;
            command_t exp;
            string    axis_name [bdot_pkg::NUM_AXES];
            axis_name = '{"x", "y", "z"};
            got = command_t'(d);
            if (pending_cmds.size() == 0)
            begin
                $display("%0t: unexpected command, actual %h", $time, d);
                mismatches++;
                return;
            end
            exp = pending_cmds.pop_front();
            for (int a = 0; a < bdot_pkg::NUM_AXES; a++)
            begin
                if (got[a].perc !== exp[a].perc)
                begin
                    $display("%0t: perc_%s expected %0d actual %0d", $time, axis_name[a],
                             exp[a].perc, got[a].perc);
                    mismatches++;
                end
                if (got[a].dir !== exp[a].dir)
                begin
                    $display("%0t: dir_%s expected %0b actual %0b", $time, axis_name[a],
                             exp[a].dir, got[a].dir);
                    mismatches++;
                end
            end
        endfunction
    endclass

    cmd_scoreboard sb = new();

    bdot_magnetorquer_command #(
        .SAMPLE_WIDTH(SAMPLE_BITS),
        .OUTPUT_SCALE(CMD_SCALE)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    // Sample both streams at the rising edge; the block's outputs still hold
    // their pre-edge values here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.take_sample(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_command(m_tdata);
        end
    end

    // Receiver back-pressure: alternate between always ready, coin-flip and
    // long stalls, each held for a random span of cycles.
    int rx_mode = 0;
    int rx_span = 0;

    always @(negedge clk)
    begin
        if (rx_span == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_span = $urandom_range(20, 300);
        end
        rx_span = rx_span - 1;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Abort when nothing moves on any port for too long.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Present one sample and hold it until the block takes it.
    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic hold_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Hold off until every predicted command has come back.
    task automatic wait_drain();
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup then access; junk in the upper bits must be ignored.
    task automatic write_reg(logic idx, logic bit0);
        logic [31:0] junk;
        junk = $urandom();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:1], bit0};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, bit0);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_mode(logic pol, logic filt);
        hold_input();
        wait_drain();
        write_reg(bdot_pkg::REG_POLARITY, pol);
        write_reg(bdot_pkg::REG_FILTER, filt);
    endtask

    // Mix of full-range, near-zero and rail values so normalization sees
    // both tiny and dominant components.
    function automatic logic [15:0] rand_axis();
        logic [15:0] rails [6];
        rails = '{16'h8000, 16'h8001, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
        case ($urandom_range(0, 5))
            0, 1, 2: return 16'($urandom());
            3:       return 16'($signed($urandom_range(0, 16)) - 8);
            4:       return rails[$urandom_range(0, 5)];
            default: return 16'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic random_phase();
        int sent;
        int burst;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(1, 8);
            for (int i = 0; i < burst && sent < PHASE_ITEMS; i++)
            begin
                send_sample(rand_axis(), rand_axis(), rand_axis());
                sent++;
            end
            hold_input();
            // Now and then let the pipeline run completely dry.
            if ($urandom_range(0, 24) == 0)
                wait_drain();
            else
                repeat ($urandom_range(0, 45)) @(negedge clk);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers at reset: no filtering, normal polarity.
        send_sample(16'h0000, 16'h0000, 16'h0000);    // zero vector
        send_sample(16'h7fff, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h7fff);
        send_sample(16'h8000, 16'h8000, 16'h8000);    // three-way tie
        send_sample(16'h7fff, 16'h8001, 16'h0001);    // tiny component truncates to zero
        send_sample(16'h0001, 16'hffff, 16'h0000);
        send_sample(16'hffff, 16'hffff, 16'hffff);
        send_sample(16'd100, -16'sd50, 16'd33);
        send_sample(16'd3, -16'sd2, 16'd1);
        send_sample(16'h8000, 16'd327, -16'sd328);
        send_sample(16'h7fff, 16'h7fff, 16'h8000);

        // Flipped polarity.
        set_mode(1'b1, 1'b0);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0001, 16'hffff);
        send_sample(16'd5, -16'sd5, 16'd0);

        // Low-pass filter on; negative sums exercise the floor.
        set_mode(1'b0, 1'b1);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000, 16'h7fff);
        send_sample(16'h0001, 16'h0001, 16'h0001);
        send_sample(16'hffff, 16'hffff, 16'hffff);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(-16'sd3, 16'd0, 16'd3);
        send_sample(16'h0000, 16'h0000, 16'h0000);

        set_mode(1'b1, 1'b0);
        random_phase();
        set_mode(1'b0, 1'b1);
        random_phase();
        set_mode(1'b1, 1'b1);
        random_phase();
        set_mode(1'b0, 1'b0);
        random_phase();
        set_mode(1'b1, 1'b1);
        random_phase();

        hold_input();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
